@@ design/three_wire_rtc_serial_master_core_defines.svh @@
// ---------------------------------------------------------------------------
// Three-wire RTC serial master: assertion macros
// Shared property shapes for the port checker.
// ---------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_CORE_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TWRTC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("twrtc check failed");

// Next-cycle implication, checked outside reset
`define TWRTC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("twrtc check failed");

`endif

@@ design/twrtc_pkg.sv @@
// ---------------------------------------------------------------------------
// Three-wire RTC serial master package
// Shared constants, codes, result type and the BCD conversion.
// ---------------------------------------------------------------------------
`default_nettype none

package twrtc_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int HALF_W        = 6;
  localparam int SEND_W        = 2 * BITS_PER_BYTE;

  // Half-bit counts: end of address phase, end of whole transfer
  localparam logic [HALF_W-1:0] ADDR_HALVES = HALF_W'(2 * BITS_PER_BYTE);
  localparam logic [HALF_W-1:0] ALL_HALVES  = HALF_W'(4 * BITS_PER_BYTE);

  // Item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic       rejected;
    logic [7:0] read_raw;
    logic [6:0] read_decimal;
  } result_t;

  // BCD byte to decimal, bit 7 ignored: low + 8*hi + 2*hi
  function automatic logic [6:0] bcd_value(input logic [7:0] raw);
    logic [2:0] hi;
    hi = raw[6:4];
    return 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(raw[3:0]);
  endfunction

endpackage

`default_nettype wire

@@ design/twrtc_engine.sv @@
// ---------------------------------------------------------------------------
// Three-wire RTC serial master: line engine
// Holds the link state and works out one half-bit step per accepted beat.
// ---------------------------------------------------------------------------
`default_nettype none

module twrtc_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [1:0]        func,
  input  wire logic [7:0]        reg_addr,
  input  wire logic [7:0]        write_data,
  input  wire logic              io_in,
  output twrtc_pkg::result_t     res
);
  import twrtc_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  mode_t                         mode_r, mode_nxt;
  logic                          en_r, en_nxt;
  logic                          sclk_r, sclk_nxt;
  logic                          data_r, data_nxt;
  logic                          drive_r, drive_nxt;
  logic [HALF_W-1:0]             cnt_r, cnt_nxt;
  logic [SEND_W-1:0]             send_r, send_nxt;
  logic [BITS_PER_BYTE-1:0]      recv_r, recv_nxt;
  logic                          done;
  logic                          rej;
  logic [7:0]                    raw;
  logic                          receiving;

  // Next state of the link for one beat
  always_comb begin
    mode_nxt  = mode_r;
    en_nxt    = en_r;
    sclk_nxt  = sclk_r;
    data_nxt  = data_r;
    drive_nxt = drive_r;
    cnt_nxt   = cnt_r;
    send_nxt  = send_r;
    recv_nxt  = recv_r;
    done      = 1'b0;
    rej       = 1'b0;
    raw       = 8'd0;
    receiving = (mode_r == MODE_READ) && (cnt_r >= ADDR_HALVES);
    if (func == FUNC_WRITE || func == FUNC_READ) begin
      if (mode_r != MODE_IDLE) begin
        // busy: drop the start, repeat the lines
        rej = 1'b1;
      end else begin
        mode_nxt  = (func == FUNC_WRITE) ? MODE_WRITE : MODE_READ;
        en_nxt    = 1'b1;
        sclk_nxt  = 1'b0;
        cnt_nxt   = '0;
        send_nxt  = {write_data, reg_addr};
        data_nxt  = 1'b0;
        drive_nxt = 1'b1;
      end
    end else if (mode_r != MODE_IDLE) begin
      if (cnt_r >= ALL_HALVES) begin
        // closing tick: release everything and report
        if (mode_r == MODE_READ) begin
          raw = recv_r;
        end
        done      = 1'b1;
        mode_nxt  = MODE_IDLE;
        en_nxt    = 1'b0;
        sclk_nxt  = 1'b0;
        cnt_nxt   = '0;
        data_nxt  = 1'b0;
        drive_nxt = 1'b0;
      end else begin
        if (!cnt_r[0]) begin
          // clock-low half: shift a bit out or sample one in
          sclk_nxt = 1'b0;
          if (receiving) begin
            drive_nxt = 1'b0;
            data_nxt  = 1'b0;
            recv_nxt  = {io_in, recv_r[BITS_PER_BYTE-1:1]};
          end else begin
            drive_nxt = 1'b1;
            data_nxt  = send_r[0];
            send_nxt  = {1'b0, send_r[SEND_W-1:1]};
          end
        end else begin
          sclk_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + HALF_W'(1);
      end
    end
  end

  // Result of this beat, from the next state
  always_comb begin
    res.chip_enable  = en_nxt;
    res.serial_clock = sclk_nxt;
    res.io_out       = drive_nxt & data_nxt;
    res.io_drive     = drive_nxt;
    res.busy_res     = (mode_nxt != MODE_IDLE);
    res.done_res     = done;
    res.rejected     = rej;
    res.read_raw     = raw;
    res.read_decimal = bcd_value(raw);
  end

  // Advance the link state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      en_r    <= 1'b0;
      sclk_r  <= 1'b0;
      data_r  <= 1'b0;
      drive_r <= 1'b0;
      cnt_r   <= '0;
      send_r  <= '0;
      recv_r  <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      en_r    <= en_nxt;
      sclk_r  <= sclk_nxt;
      data_r  <= data_nxt;
      drive_r <= drive_nxt;
      cnt_r   <= cnt_nxt;
      send_r  <= send_nxt;
      recv_r  <= recv_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/twrtc_outbuf.sv @@
// ---------------------------------------------------------------------------
// Three-wire RTC serial master: result buffer
// Output register plus one skid entry, so input waits on out_stall only once both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module twrtc_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire twrtc_pkg::result_t push_res,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output twrtc_pkg::result_t     out_res,
  output logic                   full
);
  import twrtc_pkg::*;

  logic    head_valid_r;
  logic    skid_valid_r;
  result_t head_r;
  result_t skid_r;
  logic    head_free;

  assign head_free = !head_valid_r || !out_stall;

  // Valid flags: head refills from skid first, then from the new beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_free) begin
      head_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
      end else if (push) begin
        head_r <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  assign out_valid = head_valid_r;
  assign out_res   = head_r;
  assign full      = skid_valid_r;

endmodule

`default_nettype wire

@@ design/three_wire_rtc_serial_master_core.sv @@
// ---------------------------------------------------------------------------
// Three-wire RTC serial master core
// One half bit period per beat: start, shift address and data, close.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | func, reg_addr, write_data, io_in
//  out_    | output    | out_valid / out_stall| line levels, status, read byte
//
//  One beat per cycle unless in_stall; results go to the output register or skid entry.
//  The line-state update is a single registered step, which sets that rate.
//  Synchronous active-low reset returns the lines to idle and clears results.
//  A two-entry result buffer raises in_stall only once both entries are full.
// ---------------------------------------------------------------------------
`default_nettype none

module three_wire_rtc_serial_master_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_reg_addr,
  input  wire logic [7:0] in_write_data,
  input  wire logic       in_io_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_chip_enable,
  output logic            out_serial_clock,
  output logic            out_io_out,
  output logic            out_io_drive,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic            out_rejected,
  output logic [7:0]      out_read_raw,
  output logic [6:0]      out_read_decimal
);
  import twrtc_pkg::*;

  logic    in_fire;
  logic    buf_full;
  result_t step_res;
  result_t out_res;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  twrtc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .func       (in_func),
    .reg_addr   (in_reg_addr),
    .write_data (in_write_data),
    .io_in      (in_io_in),
    .res        (step_res)
  );

  twrtc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_res  (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .full      (buf_full)
  );

  // Unpack the result beat onto its ports
  assign out_chip_enable  = out_res.chip_enable;
  assign out_serial_clock = out_res.serial_clock;
  assign out_io_out       = out_res.io_out;
  assign out_io_drive     = out_res.io_drive;
  assign out_busy_res     = out_res.busy_res;
  assign out_done_res     = out_res.done_res;
  assign out_rejected     = out_res.rejected;
  assign out_read_raw     = out_res.read_raw;
  assign out_read_decimal = out_res.read_decimal;

endmodule

`default_nettype wire

@@ design/twrtc_checker.sv @@
// ---------------------------------------------------------------------------
// Three-wire RTC serial master: port checker
// Watches the top-level ports for result consistency over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "three_wire_rtc_serial_master_core_defines.svh"

module twrtc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_chip_enable,
  input wire logic       out_io_out,
  input wire logic       out_io_drive,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic       out_rejected,
  input wire logic [7:0] out_read_raw,
  input wire logic [6:0] out_read_decimal
);

  // A closing beat leaves the link released and idle
  `TWRTC_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid && out_done_res, !out_busy_res && !out_chip_enable && !out_io_drive)

  // A start is only refused while a transfer runs
  `TWRTC_ASSERT_NOW(a_reject_busy, clk, rst_n, out_valid && out_rejected, out_busy_res && out_chip_enable)

  // Read byte fields stay zero except on a closing beat
  `TWRTC_ASSERT_NOW(a_read_only_done, clk, rst_n, out_valid && !out_done_res, out_read_raw == 8'd0 && out_read_decimal == 7'd0)

  // A released data line carries no driven level
  `TWRTC_ASSERT_NOW(a_release_low, clk, rst_n, out_valid && !out_io_drive, !out_io_out)

  // A stalled result beat holds
  `TWRTC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_read_raw) && $stable(out_done_res))

endmodule

bind three_wire_rtc_serial_master_core twrtc_checker u_twrtc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_chip_enable  (out_chip_enable),
  .out_io_out       (out_io_out),
  .out_io_drive     (out_io_drive),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_rejected     (out_rejected),
  .out_read_raw     (out_read_raw),
  .out_read_decimal (out_read_decimal)
);

`default_nettype wire
